// ===== src/ssc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ssc_pkg;

  localparam int unsigned NumBits   = 17;  // width of the calibration dividend
  localparam int unsigned CntBits   = 5;   // holds NumBits
  localparam int unsigned AddrBits  = 3;
  localparam int unsigned WdataBits = 16;

  localparam logic [7:0] HEADER_BYTE = 8'hAA;
  localparam logic [7:0] ANGLE_MAX   = 8'd180;
  localparam logic [6:0] CAL_SCALE   = 7'd100;

  // register indexes of the configuration port
  localparam logic [AddrBits-1:0] REG_RAW_MODE      = 3'd0;
  localparam logic [AddrBits-1:0] REG_SLOPE_AXIS1   = 3'd1;
  localparam logic [AddrBits-1:0] REG_OFFSET_AXIS1  = 3'd2;
  localparam logic [AddrBits-1:0] REG_SLOPE_AXIS2   = 3'd3;
  localparam logic [AddrBits-1:0] REG_OFFSET_AXIS2  = 3'd4;
  localparam logic [AddrBits-1:0] REG_TIMEOUT_STEPS = 3'd5;

  // reset values
  localparam logic [7:0]  RST_SLOPE_AXIS1   = 8'd90;
  localparam logic [15:0] RST_OFFSET_AXIS1  = 16'd380;
  localparam logic [7:0]  RST_SLOPE_AXIS2   = 8'd91;
  localparam logic [15:0] RST_OFFSET_AXIS2  = 16'd1091;
  localparam logic [15:0] RST_TIMEOUT_STEPS = 16'd200;
  localparam logic [7:0]  RST_TARGET_LOW    = 8'd45;
  localparam logic [7:0]  RST_ANGLE_MID     = 8'd90;
  localparam logic [7:0]  RST_STEP_PERIOD   = 8'd10;

  // frame positions
  localparam logic [2:0] FRAME_HEADER = 3'd0;
  localparam logic [2:0] FRAME_AXIS1  = 3'd1;
  localparam logic [2:0] FRAME_AXIS2  = 3'd2;
  localparam logic [2:0] FRAME_AXIS3  = 3'd3;
  localparam logic [2:0] FRAME_PERIOD = 3'd4;

  localparam int unsigned OutBits = 32;

  typedef struct packed {
    logic load;       // capture the input item
    logic div_start;  // launch the calibration divide
    logic commit;     // update state and load the output register
  } ssc_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_done;
    logic out_free;
  } ssc_status_t;

endpackage
`default_nettype wire

// ===== src/ssc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ssc_div import ssc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [NumBits-1:0] dividend_i,
  input  wire logic [7:0]         divisor_i,
  output logic                    done_o,
  output logic [NumBits-1:0]      quotient_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [NumBits-1:0] quo_q, quo_d;
  logic [7:0]         rem_q, rem_d;
  logic [7:0]         dvs_q, dvs_d;
  logic [8:0]         trial;
  logic [8:0]         diff;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[NumBits-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(NumBits);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[7:0];
        quo_d = {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        quo_d = {quo_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== src/ssc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ssc_datapath import ssc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ssc_cmd_t             cmd_i,
  output ssc_status_t               status_o,
  input  wire logic                 op_i,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [AddrBits-1:0]  cfg_addr_i,
  input  wire logic [WdataBits-1:0] cfg_wdata_i,
  output logic                      out_valid_o,
  output logic [OutBits-1:0]        out_data_o,
  input  wire logic                 out_ready_i
);

  logic        raw_mode_q;
  logic [7:0]  slope1_q, slope2_q;
  logic [15:0] offset1_q, offset2_q, timeout_q;

  logic        op_q;
  logic [7:0]  byte_q;

  logic [2:0]       fi_q, fi_d;
  logic [2:0][7:0]  tgt_q, tgt_d;
  logic [2:0][7:0]  cur_q, cur_d;
  logic [2:0][7:0]  step_cur;
  logic [7:0]       period_q, period_d;
  logic [7:0]       ms_q, ms_d, ms_inc;
  logic [15:0]      cnt_q, cnt_d, cnt_arr, cnt_inc;
  logic             moving_q, moving_d, moving_arr;
  logic             arrived, ack;
  logic             out_valid_q;
  logic [OutBits-1:0] out_data_q;

  logic               axis1_sel;
  logic [NumBits-1:0] dividend;
  logic [NumBits-1:0] quotient;
  logic               div_done;
  logic [7:0]         cal_angle;

  function automatic logic [7:0] sat_angle(input logic [NumBits-1:0] v);
    sat_angle = (v > NumBits'(ANGLE_MAX)) ? ANGLE_MAX : v[7:0];
  endfunction

  assign axis1_sel = (fi_q == FRAME_AXIS1);
  assign dividend  = NumBits'({9'd0, byte_q} * NumBits'(CAL_SCALE))
                   + NumBits'(axis1_sel ? offset1_q : offset2_q);

  ssc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (axis1_sel ? slope1_q : slope2_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign cal_angle = raw_mode_q ? sat_angle(NumBits'(byte_q)) : sat_angle(quotient);

  // one degree toward the target on every axis
  always_comb begin
    arrived = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (cur_q[i] > tgt_q[i]) begin
        step_cur[i] = cur_q[i] - 1'b1;
      end else if (cur_q[i] < tgt_q[i]) begin
        step_cur[i] = cur_q[i] + 1'b1;
      end else begin
        step_cur[i] = cur_q[i];
      end
      if (step_cur[i] != tgt_q[i]) arrived = 1'b0;
    end
  end

  assign moving_arr = moving_q && !arrived;
  assign cnt_arr    = (moving_q && arrived) ? 16'd0 : cnt_q;
  assign cnt_inc    = cnt_arr + 16'd1;
  assign ms_inc     = ms_q + 8'd1;

  always_comb begin
    fi_d     = fi_q;
    tgt_d    = tgt_q;
    cur_d    = cur_q;
    period_d = period_q;
    ms_d     = ms_q;
    cnt_d    = cnt_q;
    moving_d = moving_q;
    ack      = 1'b0;
    if (cmd_i.commit) begin
      if (!op_q) begin
        unique case (fi_q)
          FRAME_HEADER: begin
            if (byte_q == HEADER_BYTE) fi_d = FRAME_AXIS1;
          end
          FRAME_AXIS1: begin
            tgt_d[0] = cal_angle;
            fi_d     = FRAME_AXIS2;
          end
          FRAME_AXIS2: begin
            tgt_d[1] = cal_angle;
            fi_d     = FRAME_AXIS3;
          end
          FRAME_AXIS3: begin
            tgt_d[2] = sat_angle(NumBits'(byte_q));
            fi_d     = FRAME_PERIOD;
          end
          default: begin
            period_d = byte_q;
            moving_d = 1'b1;
            fi_d     = FRAME_HEADER;
          end
        endcase
      end else if (fi_q == FRAME_HEADER) begin
        if (ms_inc >= period_q) begin
          ms_d  = '0;
          cur_d = step_cur;
          ack   = moving_q && arrived;
          if (cnt_inc == timeout_q) begin
            ack      = 1'b1;
            moving_d = 1'b0;
            cnt_d    = '0;
          end else begin
            moving_d = moving_arr;
            cnt_d    = cnt_inc;
          end
        end else begin
          ms_d = ms_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mode_q  <= 1'b0;
      slope1_q    <= RST_SLOPE_AXIS1;
      offset1_q   <= RST_OFFSET_AXIS1;
      slope2_q    <= RST_SLOPE_AXIS2;
      offset2_q   <= RST_OFFSET_AXIS2;
      timeout_q   <= RST_TIMEOUT_STEPS;
      fi_q        <= FRAME_HEADER;
      tgt_q       <= {RST_ANGLE_MID, RST_TARGET_LOW, RST_TARGET_LOW};
      cur_q       <= {RST_ANGLE_MID, RST_ANGLE_MID, RST_ANGLE_MID};
      period_q    <= RST_STEP_PERIOD;
      ms_q        <= '0;
      cnt_q       <= '0;
      moving_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_RAW_MODE:      raw_mode_q <= cfg_wdata_i[0];
          REG_SLOPE_AXIS1:   slope1_q   <= cfg_wdata_i[7:0];
          REG_OFFSET_AXIS1:  offset1_q  <= cfg_wdata_i;
          REG_SLOPE_AXIS2:   slope2_q   <= cfg_wdata_i[7:0];
          REG_OFFSET_AXIS2:  offset2_q  <= cfg_wdata_i;
          REG_TIMEOUT_STEPS: timeout_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      fi_q     <= fi_d;
      tgt_q    <= tgt_d;
      cur_q    <= cur_d;
      period_q <= period_d;
      ms_q     <= ms_d;
      cnt_q    <= cnt_d;
      moving_q <= moving_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      byte_q <= rx_byte_i;
    end
    if (cmd_i.commit) begin
      out_data_q <= {6'd0, moving_d, ack, cur_d[2], cur_d[1], cur_d[0]};
    end
  end

  assign status_o.needs_div = !op_q && !raw_mode_q
                            && (fi_q == FRAME_AXIS1 || fi_q == FRAME_AXIS2);
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ===== src/ssc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ssc_ctrl import ssc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire ssc_status_t status_i,
  output ssc_cmd_t         cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StWait  = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (status_i.needs_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = StWait;
        end else begin
          state_d = StEmit;
        end
      end
      StWait: begin
        if (status_i.div_done) state_d = StEmit;
      end
      default: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

endmodule
`default_nettype wire

// ===== src/servo_slew_command_controller_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Three-axis servo slew controller.
// Input channel s_axis: one item per received serial byte (tuser = 0, byte in
// tdata) or per millisecond tick (tuser = 1). A frame is 0xAA followed by the
// axis-1, axis-2, axis-3 and step-period bytes. Output channel m_axis: one
// item per input item with the three current angles, the acknowledge flag and
// the busy flag.
// Configuration: cfg_we_i writes register cfg_addr_i (0 raw mode, 1/2 slope
// and offset of axis 1, 3/4 of axis 2, 5 timeout steps); write while idle.
// Flow: an item is taken in the idle state, decoded in the check state and
// committed to the output register in the emit state, which holds while the
// output register is full. Axis-1 and axis-2 bytes in calibrated mode also
// pass a wait state for the restoring divider. s_axis_tready is high only
// between items, so a new item is taken only after the last is committed.
// Reset clears the frame decoder and loads the default calibration, targets
// (45, 45, 90) and angles (90, 90, 90). A stalled receiver leaves the result in
// the output register; the next item is still taken and decoded, and waits at
// commit until the output register frees.
module servo_slew_command_controller_top import ssc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
  input  wire logic                 s_axis_tuser,   // [0] op
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [7:0] angle_one, [15:8] angle_two, [23:16] angle_three, [24] ack,
  // [25] busy_res, [31:26] zero
  output logic [OutBits-1:0]        m_axis_tdata,
  input  wire logic                 cfg_we_i,
  input  wire logic [AddrBits-1:0]  cfg_addr_i,
  input  wire logic [WdataBits-1:0] cfg_wdata_i
);

  ssc_cmd_t    cmd;
  ssc_status_t status;

  ssc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .op_i        (s_axis_tuser),
    .rx_byte_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_ready_i (m_axis_tready)
  );

endmodule
`default_nettype wire

// ===== src/ssc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ssc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // one item at a time: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // a new result only appears while an item is in flight
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without an accepted item");

  // angles never exceed 180 and padding stays zero
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] <= 8'd180) && (m_axis_tdata[15:8] <= 8'd180)
      && (m_axis_tdata[23:16] <= 8'd180) && (m_axis_tdata[31:26] == 6'd0))
    else $error("angle out of range or padding set");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind servo_slew_command_controller_top ssc_checker u_ssc_checker (.*);
`default_nettype wire

// ===== tb/sv/servo_slew_checker.sv =====
`timescale 1ns / 1ps
package ssc_tb_pkg;

  // item kinds on s_axis_tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

endpackage

module servo_slew_checker import ssc_pkg::*; import ssc_tb_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  input  wire logic                 s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,
  input  wire logic                 s_axis_tuser,
  input  wire logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  input  wire logic [OutBits-1:0]   m_axis_tdata,
  input  wire logic                 cfg_we_i,
  input  wire logic [AddrBits-1:0]  cfg_addr_i,
  input  wire logic [WdataBits-1:0] cfg_wdata_i,
  output int                        err_cnt_o,
  output int                        pending_o,
  output int                        checked_cnt_o,
  output int                        ack_cnt_o
);

  // laid out as m_axis_tdata, lowest field last
  typedef struct packed {
    logic [5:0] pad;
    logic       busy;
    logic       ack;
    logic [7:0] ang3;
    logic [7:0] ang2;
    logic [7:0] ang1;
  } servo_report_t;

  logic        raw_mode_q;
  logic [7:0]  slope_q [2];
  logic [15:0] offset_q [2];
  logic [15:0] timeout_q;

  logic [2:0]  frame_pos;
  logic [7:0]  target_ang [3];
  logic [7:0]  servo_ang [3];
  logic [7:0]  period_ms;
  logic [7:0]  ms_count;
  logic [15:0] step_cnt;
  logic        move_active;

  servo_report_t angle_reports_q [$];

  function automatic logic [7:0] clamp_angle(input logic [16:0] v);
    return (v > 17'(ANGLE_MAX)) ? ANGLE_MAX : v[7:0];
  endfunction

  function automatic logic [7:0] map_axis(input logic [7:0] b, input int ax);
    logic [16:0] num;
    if (raw_mode_q) return clamp_angle(17'(b));
    if (slope_q[ax] == 8'd0) return ANGLE_MAX;
    num = 17'(b) * 17'(CAL_SCALE) + 17'(offset_q[ax]);
    return clamp_angle(num / 17'(slope_q[ax]));
  endfunction

  // one degree toward target on every axis; returns the acknowledge
  function automatic logic slew_step();
    logic hit;
    logic arrived;
    hit = 1'b0;
    arrived = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (servo_ang[i] > target_ang[i]) servo_ang[i] = servo_ang[i] - 8'd1;
      else if (servo_ang[i] < target_ang[i]) servo_ang[i] = servo_ang[i] + 8'd1;
      if (servo_ang[i] != target_ang[i]) arrived = 1'b0;
    end
    if (move_active && arrived) begin
      hit = 1'b1;
      move_active = 1'b0;
      step_cnt = '0;
    end
    step_cnt = step_cnt + 16'd1;
    if (step_cnt == timeout_q) begin
      hit = 1'b1;
      move_active = 1'b0;
      step_cnt = '0;
    end
    return hit;
  endfunction

  function automatic servo_report_t servo_next_result(input logic op, input logic [7:0] b);
    servo_report_t r;
    logic ack;
    ack = 1'b0;
    if (op == OP_BYTE) begin
      case (frame_pos)
        FRAME_HEADER: if (b == HEADER_BYTE) frame_pos = FRAME_AXIS1;
        FRAME_AXIS1: begin
          target_ang[0] = map_axis(b, 0);
          frame_pos = FRAME_AXIS2;
        end
        FRAME_AXIS2: begin
          target_ang[1] = map_axis(b, 1);
          frame_pos = FRAME_AXIS3;
        end
        FRAME_AXIS3: begin
          target_ang[2] = clamp_angle(17'(b));
          frame_pos = FRAME_PERIOD;
        end
        default: begin
          period_ms = b;
          move_active = 1'b1;
          frame_pos = FRAME_HEADER;
        end
      endcase
    end else if (frame_pos == FRAME_HEADER) begin
      // ticks inside a frame do not advance the timer
      ms_count = ms_count + 8'd1;
      if (ms_count >= period_ms) begin
        ms_count = '0;
        ack = slew_step();
      end
    end
    r.pad  = '0;
    r.busy = move_active;
    r.ack  = ack;
    r.ang3 = servo_ang[2];
    r.ang2 = servo_ang[1];
    r.ang1 = servo_ang[0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    servo_report_t got;
    servo_report_t want;
    if (!rst_ni) begin
      raw_mode_q    <= 1'b0;
      slope_q[0]    <= RST_SLOPE_AXIS1;
      offset_q[0]   <= RST_OFFSET_AXIS1;
      slope_q[1]    <= RST_SLOPE_AXIS2;
      offset_q[1]   <= RST_OFFSET_AXIS2;
      timeout_q     <= RST_TIMEOUT_STEPS;
      frame_pos     <= FRAME_HEADER;
      target_ang[0] <= RST_TARGET_LOW;
      target_ang[1] <= RST_TARGET_LOW;
      target_ang[2] <= RST_ANGLE_MID;
      for (int i = 0; i < 3; i++) servo_ang[i] <= RST_ANGLE_MID;
      period_ms     <= RST_STEP_PERIOD;
      ms_count      <= '0;
      step_cnt      <= '0;
      move_active   <= 1'b0;
      angle_reports_q.delete();
      err_cnt_o     <= 0;
      pending_o     <= 0;
      checked_cnt_o <= 0;
      ack_cnt_o     <= 0;
    end else begin
      // compare before push: a result never belongs to an item taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = servo_report_t'(m_axis_tdata);
        if (angle_reports_q.size() == 0) begin
          err_cnt_o = err_cnt_o + 1;
          if (err_cnt_o <= 10)
            $display("%0t: unexpected result %h with nothing pending", $realtime, m_axis_tdata);
        end else begin
          want = angle_reports_q.pop_front();
          checked_cnt_o = checked_cnt_o + 1;
          if (got.ack) ack_cnt_o = ack_cnt_o + 1;
          if (got.ang1 !== want.ang1 || got.ang2 !== want.ang2 ||
              got.ang3 !== want.ang3 || got.ack !== want.ack ||
              got.busy !== want.busy || got.pad !== want.pad) begin
            err_cnt_o = err_cnt_o + 1;
            if (err_cnt_o <= 10)
              $display("%0t: mismatch angles %0d/%0d/%0d ack %b busy %b pad %h, want %0d/%0d/%0d ack %b busy %b pad %h",
                       $realtime, got.ang1, got.ang2, got.ang3, got.ack, got.busy, got.pad,
                       want.ang1, want.ang2, want.ang3, want.ack, want.busy, want.pad);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        angle_reports_q.push_back(servo_next_result(s_axis_tuser, s_axis_tdata));
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_RAW_MODE:      raw_mode_q = cfg_wdata_i[0];
          REG_SLOPE_AXIS1:   slope_q[0] = cfg_wdata_i[7:0];
          REG_OFFSET_AXIS1:  offset_q[0] = cfg_wdata_i;
          REG_SLOPE_AXIS2:   slope_q[1] = cfg_wdata_i[7:0];
          REG_OFFSET_AXIS2:  offset_q[1] = cfg_wdata_i;
          REG_TIMEOUT_STEPS: timeout_q = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o = angle_reports_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_servo_slew_command_controller_top.sv =====
`timescale 1ns / 1ps
module tb_servo_slew_command_controller_top;
  import ssc_pkg::*;
  import ssc_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 30;   // longer than the divider path
  localparam int          NUM_SETTINGS  = 5;
  localparam int          ITEMS_PER_SET = 100;

  // indexes past the last register; writes there must be dropped
  localparam logic [AddrBits-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [AddrBits-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;   // [7:0] rx_byte
  logic                 s_axis_tuser = 1'b0; // [0] op
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [7:0] angle_one, [15:8] angle_two, [23:16] angle_three, [24] ack, [25] busy_res
  logic [OutBits-1:0]   m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [AddrBits-1:0]  cfg_addr_i = '0;
  logic [WdataBits-1:0] cfg_wdata_i = '0;

  int          err_cnt;
  int          pending;
  int          checked_cnt;
  int          ack_cnt;
  int          burst_left = 0;
  int          items_sent = 0;
  int          ready_hold = 0;
  int unsigned cycle_cnt = 0;
  logic        near_mid_bias = 1'b0;

  servo_slew_command_controller_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  servo_slew_checker slew_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending),
    .checked_cnt_o (checked_cnt),
    .ack_cnt_o     (ack_cnt)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: long ready stretches, stall runs and single-cycle jitter
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          m_axis_tready <= 1'b1;
          ready_hold <= $urandom_range(10, 60);
        end
        1: begin
          m_axis_tready <= 1'b0;
          ready_hold <= $urandom_range(1, 25);
        end
        default: m_axis_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // called just after a falling edge; returns just after the falling edge that follows the accept
  task automatic send_item(input logic op, input logic [7:0] b, input bit counted);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 25)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = b;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
    if (counted) items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [AddrBits-1:0] addr, input logic [WdataBits-1:0] data);
    cfg_we_i = 1'b1;
    cfg_addr_i = addr;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_setting(input int idx);
    logic [WdataBits-1:0] regs [6];
    regs[REG_RAW_MODE]      = '0;
    regs[REG_SLOPE_AXIS1]   = 16'(RST_SLOPE_AXIS1);
    regs[REG_OFFSET_AXIS1]  = RST_OFFSET_AXIS1;
    regs[REG_SLOPE_AXIS2]   = 16'(RST_SLOPE_AXIS2);
    regs[REG_OFFSET_AXIS2]  = RST_OFFSET_AXIS2;
    regs[REG_TIMEOUT_STEPS] = 16'($urandom_range(1, 300));
    case (idx)
      0: begin
        // saturating calibration on axis 1, plain scaling on axis 2, ack every step
        regs[REG_SLOPE_AXIS1]   = 16'd1;
        regs[REG_OFFSET_AXIS1]  = 16'hFFFF;
        regs[REG_SLOPE_AXIS2]   = 16'd255;
        regs[REG_OFFSET_AXIS2]  = 16'd0;
        regs[REG_TIMEOUT_STEPS] = 16'd1;
      end
      1: begin
        regs[REG_RAW_MODE]      = 16'd1;
        regs[REG_SLOPE_AXIS1]   = 16'd255;
        regs[REG_OFFSET_AXIS1]  = 16'd0;
        regs[REG_SLOPE_AXIS2]   = 16'd1;
        regs[REG_OFFSET_AXIS2]  = 16'hFFFF;
        regs[REG_TIMEOUT_STEPS] = 16'hFFFF;
      end
      2: begin
        regs[REG_SLOPE_AXIS1]   = 16'($urandom_range(1, 255));
        regs[REG_OFFSET_AXIS1]  = 16'($urandom_range(0, 65535));
        regs[REG_SLOPE_AXIS2]   = 16'($urandom_range(1, 255));
        regs[REG_OFFSET_AXIS2]  = 16'($urandom_range(0, 2000));
        regs[REG_TIMEOUT_STEPS] = 16'($urandom_range(2, 12));
      end
      3: begin
        // zero slope pins calibrated targets at the top of the range
        regs[REG_SLOPE_AXIS1]   = 16'd0;
        regs[REG_OFFSET_AXIS1]  = 16'($urandom_range(0, 65535));
        regs[REG_SLOPE_AXIS2]   = 16'd0;
        regs[REG_OFFSET_AXIS2]  = 16'($urandom_range(0, 65535));
        regs[REG_TIMEOUT_STEPS] = 16'($urandom_range(20, 60));
      end
      default: ;
    endcase
    write_reg(REG_RAW_MODE, regs[REG_RAW_MODE]);
    write_reg(REG_SLOPE_AXIS1, regs[REG_SLOPE_AXIS1]);
    write_reg(REG_OFFSET_AXIS1, regs[REG_OFFSET_AXIS1]);
    write_reg(REG_SLOPE_AXIS2, regs[REG_SLOPE_AXIS2]);
    write_reg(REG_OFFSET_AXIS2, regs[REG_OFFSET_AXIS2]);
    write_reg(REG_TIMEOUT_STEPS, regs[REG_TIMEOUT_STEPS]);
    if (idx == 2) begin
      write_reg(REG_SPARE_LO, 16'($urandom_range(0, 65535)));
      write_reg(REG_SPARE_HI, 16'($urandom_range(0, 65535)));
    end
    near_mid_bias = (idx == 1);
  endtask

  function automatic logic [7:0] pick_axis_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < (near_mid_bias ? 60 : 35)) return 8'($urandom_range(70, 100));
    if (roll < 75) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return HEADER_BYTE;
      3: return ANGLE_MAX;
      default: return ANGLE_MAX + 8'd1;
    endcase
  endfunction

  function automatic logic [7:0] pick_period_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 8'($urandom_range(0, 2));
    if (roll < 90) return 8'($urandom_range(3, 10));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_frame();
    logic [7:0] body [4];
    body[0] = pick_axis_byte();
    body[1] = pick_axis_byte();
    body[2] = pick_axis_byte();
    body[3] = pick_period_byte();
    send_item(OP_BYTE, HEADER_BYTE, 1'b1);
    for (int i = 0; i < 4; i++) begin
      // a stray tick inside the frame must be dropped
      if ($urandom_range(0, 9) == 0) send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0);
      send_item(OP_BYTE, body[i], 1'b1);
    end
  endtask

  task automatic drive_random_traffic(input int budget);
    int stop_at;
    int roll;
    int run_len;
    logic [7:0] noise;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        send_random_frame();
      end else if (roll < 90) begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 40);
        if (run_len > stop_at - items_sent) run_len = stop_at - items_sent;
        repeat (run_len) send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b1);
      end else begin
        // noise while waiting for a header
        repeat ($urandom_range(1, 3)) begin
          noise = 8'($urandom_range(0, 255));
          if (noise == HEADER_BYTE) noise = noise ^ 8'h01;
          send_item(OP_BYTE, noise, 1'b0);
        end
      end
    end
  endtask

  initial begin
    logic [8:0] opening [24];
    opening = '{
      {OP_TICK, 8'h00}, {OP_BYTE, 8'h55}, {OP_BYTE, 8'h00},
      {OP_BYTE, HEADER_BYTE}, {OP_BYTE, 8'hFF}, {OP_TICK, 8'hFF},
      {OP_BYTE, HEADER_BYTE}, {OP_BYTE, 8'hB5}, {OP_BYTE, 8'h00},
      {OP_TICK, 8'h00}, {OP_TICK, 8'h00}, {OP_TICK, 8'h00},
      {OP_TICK, 8'h00}, {OP_TICK, 8'h00}, {OP_TICK, 8'h00},
      {OP_BYTE, HEADER_BYTE}, {OP_BYTE, 8'h00}, {OP_BYTE, 8'h00},
      {OP_BYTE, 8'h00}, {OP_BYTE, 8'h01},
      {OP_TICK, 8'h00}, {OP_TICK, 8'h00}, {OP_TICK, 8'h00}, {OP_TICK, 8'h00}
    };
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset calibration: saturation, header as data, ignored bytes and ticks
    foreach (opening[i]) send_item(opening[i][8], opening[i][7:0], 1'b1);
    wait_idle();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      load_setting(s);
      drive_random_traffic(ITEMS_PER_SET);
      wait_idle();
    end

    $display("run: %0d items over %0d register settings plus reset defaults",
             items_sent, NUM_SETTINGS);
    $display("run: %0d results checked, %0d acknowledges seen", checked_cnt, ack_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
